[sv/pbi_pkg.sv]
// pbi_pkg: shared types and constants for the particle box integrator.
// No dependencies; imported by pbi_lane, pbi_bound, particle_box_integrator and tb.
package pbi_pkg;

	// Fraction bits of the random fraction and of the restitution factor
	localparam int RAND_FRAC = 16;
	localparam int BF_BITS   = 17;
	localparam int IDX_BITS  = 3;

	// Configuration register indexes
	typedef enum logic [IDX_BITS-1:0] {
		IDX_TIME_STEP     = 3'd0,
		IDX_LEFT_BOUND    = 3'd1,
		IDX_RIGHT_BOUND   = 3'd2,
		IDX_UPPER_BOUND   = 3'd3,
		IDX_LOWER_BOUND   = 3'd4,
		IDX_BOUNCE_FACTOR = 3'd5
	} cfg_idx_t;

	// Per-stage load enables of the seven-stage pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

endpackage

[sv/particle_box_integrator.sv]
// particle_box_integrator: one particle request per cycle while the output is not stalled.
// From input accept to output valid a request passes four integration stages in the axis
// lanes and three in the boundary merge. Every stage is a register holding one request,
// so throughput is one request per clock with no stall downstream.
// arst_n clears the stage valid bits and loads the register defaults at once.
// Depends on pbi_pkg, pbi_lane and pbi_bound.
module particle_box_integrator #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [pbi_pkg::IDX_BITS-1:0]            cfg_index,
	input  logic [WORD_BITS-1:0]                    cfg_data,
	// particle input stream
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// s_tdata, low bit up: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
	// acc_x, acc_y, acc_z, random_fraction, zero pad to bytes
	input  logic [8*((9*WORD_BITS+pbi_pkg::RAND_FRAC+7)/8)-1:0] s_tdata,
	// result stream
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// m_tdata, low bit up: new_pos_x, new_pos_y, new_pos_z,
	// new_vel_x, new_vel_y, new_vel_z, zero pad to bytes
	output logic [8*((6*WORD_BITS+7)/8)-1:0]        m_tdata
);
	import pbi_pkg::*;

	localparam int W      = WORD_BITS;
	localparam int OUT_TW = 8 * ((6 * W + 7) / 8);
	localparam int NSTG   = 7;

	// register defaults: dt about 0.01, box of +/-10, restitution of one
	localparam logic [W-2:0]        DT_RESET  = (W-1)'((64'd1 << FRAC_BITS) / 100);
	localparam logic signed [W-1:0] TEN       = W'(64'd10 << FRAC_BITS);
	localparam logic [BF_BITS-1:0]  BF_RESET  = BF_BITS'(64'd1 << RAND_FRAC);

	// configuration registers
	logic        [W-2:0]       time_step_q;
	logic signed [W-1:0]       left_bound_q, right_bound_q, upper_bound_q, lower_bound_q;
	logic        [BF_BITS-1:0] bounce_factor_q;

	// pipeline control: valid per stage, a stage loads when empty or draining
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en_v;
	stage_en_t       en;

	// unpacked input fields
	logic signed [W-1:0]         pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic signed [W-1:0]         acc_x, acc_y, acc_z;
	logic        [RAND_FRAC-1:0] random_fraction;

	// lane results
	logic signed [W-1:0] lx_pos, ly_pos, lz_pos, lx_vel, ly_vel, lz_vel;

	// final results
	logic signed [W-1:0] new_pos_x, new_pos_y, new_pos_z;
	logic signed [W-1:0] new_vel_x, new_vel_y, new_vel_z;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q     <= DT_RESET;
			left_bound_q    <= -TEN;
			right_bound_q   <= TEN;
			upper_bound_q   <= TEN;
			lower_bound_q   <= -TEN;
			bounce_factor_q <= BF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				IDX_TIME_STEP:     time_step_q     <= cfg_data[W-2:0];
				IDX_LEFT_BOUND:    left_bound_q    <= $signed(cfg_data);
				IDX_RIGHT_BOUND:   right_bound_q   <= $signed(cfg_data);
				IDX_UPPER_BOUND:   upper_bound_q   <= $signed(cfg_data);
				IDX_LOWER_BOUND:   lower_bound_q   <= $signed(cfg_data);
				IDX_BOUNCE_FACTOR: bounce_factor_q <= cfg_data[BF_BITS-1:0];
				default:           ;  // unknown index: write dropped
			endcase
		end
	end

	// Enable chain runs back from the output: a bubble anywhere lets the
	// stages ahead of it keep moving while a result waits at the output.
	always_comb begin
		en_v[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en_v[i] = !vld_q[i] || en_v[i+1];
		end
	end

	assign en.s1 = en_v[0];
	assign en.s2 = en_v[1];
	assign en.s3 = en_v[2];
	assign en.s4 = en_v[3];
	assign en.s5 = en_v[4];
	assign en.s6 = en_v[5];
	assign en.s7 = en_v[6];

	assign s_tready = en_v[0];
	assign m_tvalid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en_v[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en_v[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// input field unpack
	assign pos_x           = $signed(s_tdata[0*W +: W]);
	assign pos_y           = $signed(s_tdata[1*W +: W]);
	assign pos_z           = $signed(s_tdata[2*W +: W]);
	assign vel_x           = $signed(s_tdata[3*W +: W]);
	assign vel_y           = $signed(s_tdata[4*W +: W]);
	assign vel_z           = $signed(s_tdata[5*W +: W]);
	assign acc_x           = $signed(s_tdata[6*W +: W]);
	assign acc_y           = $signed(s_tdata[7*W +: W]);
	assign acc_z           = $signed(s_tdata[8*W +: W]);
	assign random_fraction = s_tdata[9*W +: RAND_FRAC];

	// one integration lane per axis
	pbi_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_lane_x (
		.clk(clk), .en(en), .time_step(time_step_q),
		.pos(pos_x), .vel(vel_x), .acc(acc_x),
		.new_pos(lx_pos), .new_vel(lx_vel)
	);

	pbi_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_lane_y (
		.clk(clk), .en(en), .time_step(time_step_q),
		.pos(pos_y), .vel(vel_y), .acc(acc_y),
		.new_pos(ly_pos), .new_vel(ly_vel)
	);

	pbi_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_lane_z (
		.clk(clk), .en(en), .time_step(time_step_q),
		.pos(pos_z), .vel(vel_z), .acc(acc_z),
		.new_pos(lz_pos), .new_vel(lz_vel)
	);

	// merge stage: x respawn, y mirror, velocity reflection; z passes through.
	// The respawn point is formed in parallel with the lanes from the request's
	// random fraction.
	pbi_bound #(.WORD_BITS(W)) u_bound (
		.clk(clk), .en(en),
		.left_bound(left_bound_q), .right_bound(right_bound_q),
		.upper_bound(upper_bound_q), .lower_bound(lower_bound_q),
		.bounce_factor(bounce_factor_q), .random_fraction(random_fraction),
		.pos_x(lx_pos), .pos_y(ly_pos), .pos_z(lz_pos),
		.vel_x(lx_vel), .vel_y(ly_vel), .vel_z(lz_vel),
		.new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
		.new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z)
	);

	// results are the stage 7 registers, packed with zero fill
	assign m_tdata = OUT_TW'({new_vel_z, new_vel_y, new_vel_x,
	                          new_pos_z, new_pos_y, new_pos_x});

endmodule

[sv/pbi_lane.sv]
// pbi_lane: one axis of constant-acceleration integration, four stages.
// Depends on pbi_pkg (stage_en_t).
module pbi_lane #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  pbi_pkg::stage_en_t          en,
	input  logic        [WORD_BITS-2:0] time_step,
	input  logic signed [WORD_BITS-1:0] pos,
	input  logic signed [WORD_BITS-1:0] vel,
	input  logic signed [WORD_BITS-1:0] acc,
	output logic signed [WORD_BITS-1:0] new_pos,
	output logic signed [WORD_BITS-1:0] new_vel
);
	import pbi_pkg::*;

	localparam int W = WORD_BITS;

	logic signed [W-1:0]   dt_s;
	logic signed [2*W-1:0] prod_s1;
	logic signed [W-1:0]   pos_s1, vel_s1;
	logic signed [W-1:0]   half, dvel;
	logic signed [W-1:0]   sum_s2, vel_s2, pos_s2;
	logic signed [2*W-1:0] dprod_s3;
	logic signed [W-1:0]   pos_s3, vel_s3;
	logic signed [W-1:0]   pos_s4, vel_s4;

	assign dt_s = $signed({1'b0, time_step});

	// dt*acc serves both the half step and the velocity increment
	assign half = prod_s1[FRAC_BITS+1 +: W];
	assign dvel = prod_s1[FRAC_BITS +: W];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= acc * dt_s;
			pos_s1  <= pos;
			vel_s1  <= vel;
		end
		if (en.s2) begin
			sum_s2 <= vel_s1 + half;
			vel_s2 <= vel_s1 + dvel;
			pos_s2 <= pos_s1;
		end
		if (en.s3) begin
			dprod_s3 <= sum_s2 * dt_s;
			pos_s3   <= pos_s2;
			vel_s3   <= vel_s2;
		end
		if (en.s4) begin
			pos_s4 <= pos_s3 + dprod_s3[FRAC_BITS +: W];
			vel_s4 <= vel_s3;
		end
	end

	assign new_pos = pos_s4;
	assign new_vel = vel_s4;

endmodule

[sv/pbi_bound.sv]
// pbi_bound: merges the three lane results and applies the box limits on x and y.
// Depends on pbi_pkg (stage_en_t, RAND_FRAC, BF_BITS).
module pbi_bound #(
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  pbi_pkg::stage_en_t                  en,
	input  logic signed [WORD_BITS-1:0]         left_bound,
	input  logic signed [WORD_BITS-1:0]         right_bound,
	input  logic signed [WORD_BITS-1:0]         upper_bound,
	input  logic signed [WORD_BITS-1:0]         lower_bound,
	input  logic        [pbi_pkg::BF_BITS-1:0]  bounce_factor,
	input  logic        [pbi_pkg::RAND_FRAC-1:0] random_fraction,
	input  logic signed [WORD_BITS-1:0]         pos_x,
	input  logic signed [WORD_BITS-1:0]         pos_y,
	input  logic signed [WORD_BITS-1:0]         pos_z,
	input  logic signed [WORD_BITS-1:0]         vel_x,
	input  logic signed [WORD_BITS-1:0]         vel_y,
	input  logic signed [WORD_BITS-1:0]         vel_z,
	output logic signed [WORD_BITS-1:0]         new_pos_x,
	output logic signed [WORD_BITS-1:0]         new_pos_y,
	output logic signed [WORD_BITS-1:0]         new_pos_z,
	output logic signed [WORD_BITS-1:0]         new_vel_x,
	output logic signed [WORD_BITS-1:0]         new_vel_y,
	output logic signed [WORD_BITS-1:0]         new_vel_z
);
	import pbi_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int RW = W + RAND_FRAC + 1;
	localparam int BW = W + BF_BITS + 1;

	logic signed [RAND_FRAC:0] rnd_s;
	logic signed [BF_BITS:0]   bf_s;
	logic signed [W-1:0]       diff;
	logic        [W-1:0]       mag, offset;

	logic signed [RW-1:0] sprod_s1;
	logic signed [W-1:0]  spawn_s2, spawn_s3, spawn_s4;

	// stage 5 terms
	logic                 x_blw, x_abv, y_blw;
	logic signed [W-1:0]  x1, y_mir_lo, neg_vx, neg_vy;
	logic signed [W-1:0]  px_s5, py_s5, pz_s5, vx_s5, vy_s5, vz_s5;
	logic        [1:0]    nx_s5;
	logic                 yb_s5;
	logic signed [BW-1:0] rx_prod_s5, ry_prod_s5;

	// stage 6 terms
	logic                 y_abv;
	logic signed [W-1:0]  rx1, ry1, neg_rx1, neg_ry1;
	logic signed [W-1:0]  px_s6, py_s6, pz_s6, vx_s6, vy_s6, vz_s6;
	logic signed [W-1:0]  rx1_s6, ry1_s6;
	logic        [1:0]    nx_s6, ny_s6;
	logic signed [BW-1:0] rx2_prod_s6, ry2_prod_s6;

	logic signed [W-1:0]  px_s7, py_s7, pz_s7, vx_s7, vy_s7, vz_s7;

	assign rnd_s  = $signed({1'b0, random_fraction});
	assign bf_s   = $signed({1'b0, bounce_factor});
	assign diff   = right_bound - left_bound;
	assign mag    = diff[W-1] ? W'(-diff) : W'(diff);
	assign offset = mag >> 1;

	assign x_blw    = pos_x < left_bound;
	assign x1       = x_blw ? spawn_s4 : pos_x;
	assign x_abv    = right_bound < x1;
	assign y_blw    = pos_y < lower_bound;
	assign y_mir_lo = lower_bound + (lower_bound - pos_y);
	assign neg_vx   = -vel_x;
	assign neg_vy   = -vel_y;

	assign y_abv   = upper_bound < py_s5;
	assign rx1     = rx_prod_s5[RAND_FRAC +: W];
	assign ry1     = ry_prod_s5[RAND_FRAC +: W];
	assign neg_rx1 = -rx1;
	assign neg_ry1 = -ry1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sprod_s1 <= rnd_s * right_bound;
		end
		if (en.s2) begin
			spawn_s2 <= sprod_s1[RAND_FRAC +: W] - $signed(offset);
		end
		if (en.s3) begin
			spawn_s3 <= spawn_s2;
		end
		if (en.s4) begin
			spawn_s4 <= spawn_s3;
		end
		if (en.s5) begin
			px_s5      <= x_abv ? spawn_s4 : x1;
			nx_s5      <= {1'b0, x_blw} + {1'b0, x_abv};
			rx_prod_s5 <= neg_vx * bf_s;
			vx_s5      <= vel_x;
			py_s5      <= y_blw ? y_mir_lo : pos_y;
			yb_s5      <= y_blw;
			ry_prod_s5 <= neg_vy * bf_s;
			vy_s5      <= vel_y;
			pz_s5      <= pos_z;
			vz_s5      <= vel_z;
		end
		if (en.s6) begin
			px_s6       <= px_s5;
			nx_s6       <= nx_s5;
			rx1_s6      <= rx1;
			rx2_prod_s6 <= neg_rx1 * bf_s;
			vx_s6       <= vx_s5;
			py_s6       <= y_abv ? (upper_bound - (py_s5 - upper_bound)) : py_s5;
			ny_s6       <= {1'b0, yb_s5} + {1'b0, y_abv};
			ry1_s6      <= ry1;
			ry2_prod_s6 <= neg_ry1 * bf_s;
			vy_s6       <= vy_s5;
			pz_s6       <= pz_s5;
			vz_s6       <= vz_s5;
		end
		if (en.s7) begin
			px_s7 <= px_s6;
			py_s7 <= py_s6;
			pz_s7 <= pz_s6;
			vz_s7 <= vz_s6;
			case (nx_s6)
				2'd0:    vx_s7 <= vx_s6;
				2'd1:    vx_s7 <= rx1_s6;
				default: vx_s7 <= rx2_prod_s6[RAND_FRAC +: W];
			endcase
			case (ny_s6)
				2'd0:    vy_s7 <= vy_s6;
				2'd1:    vy_s7 <= ry1_s6;
				default: vy_s7 <= ry2_prod_s6[RAND_FRAC +: W];
			endcase
		end
	end

	assign new_pos_x = px_s7;
	assign new_pos_y = py_s7;
	assign new_pos_z = pz_s7;
	assign new_vel_x = vx_s7;
	assign new_vel_y = vy_s7;
	assign new_vel_z = vz_s7;

endmodule

[tb/sv/tb.sv]
// tb: self-checking bench for particle_box_integrator. Random and directed particle
// requests against an in-bench fixed-point predictor, under several box settings.
// Depends on pbi_pkg and particle_box_integrator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pbi_pkg::*;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int IN_BITS   = 8*((9*WORD_BITS+RAND_FRAC+7)/8);
	localparam int OUT_BITS  = 8*((6*WORD_BITS+7)/8);

	// Register indexes the block does not decode; writes there must change nothing
	localparam logic [IDX_BITS-1:0] IDX_SPARE_6 = 3'd6;
	localparam logic [IDX_BITS-1:0] IDX_SPARE_7 = 3'd7;

	// Q16.16 helpers
	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] HALF = 32'h0000_8000;
	localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
	localparam logic [31:0] MINW = 32'h8000_0000;

	// Laid out exactly like s_tdata / m_tdata: first field in the low bits
	typedef struct packed {
		logic [15:0]       rnd;
		logic [2:0][31:0]  acc;
		logic [2:0][31:0]  vel;
		logic [2:0][31:0]  pos;
	} particle_t;

	typedef struct packed {
		logic [2:0][31:0]  vel;
		logic [2:0][31:0]  pos;
	} motion_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] idx;
		logic [31:0]         data;
	} reg_write_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_BITS-1:0]   cfg_index = '0;
	logic [WORD_BITS-1:0]  cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// s_tdata, low bit up: pos_x..z, vel_x..z, acc_x..z, random_fraction
	logic [IN_BITS-1:0]    s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// m_tdata, low bit up: new_pos_x..z, new_vel_x..z
	logic [OUT_BITS-1:0]   m_tdata;

	// Bench copy of the box registers, reset values preloaded
	logic [30:0] box_dt     = 31'd655;
	logic [31:0] box_left   = -10 * ONE;
	logic [31:0] box_right  = 10 * ONE;
	logic [31:0] box_up     = 10 * ONE;
	logic [31:0] box_low    = -10 * ONE;
	logic [16:0] box_bounce = 17'd65536;

	particle_t  particle_q[$];     // requests still to be offered
	motion_t    motion_due_q[$];   // predicted results, oldest first
	reg_write_t reg_write_q[$];    // register writes still to be offered

	int idle_pct = 30;
	int fail_cnt = 0;
	int results_seen = 0;
	int hold_left = 0;
	int holds_done = 0;

	string field_name [6] = '{"new_pos_x", "new_pos_y", "new_pos_z",
		"new_vel_x", "new_vel_y", "new_vel_z"};

	particle_box_integrator #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Exact product, floor shift, wrap to the word. Operands never exceed
	// 32x32 bits so a 64-bit product cannot overflow.
	function automatic logic [31:0] fixed_mul(longint a, longint b, int sh);
		longint prod;
		prod = (a * b) >>> sh;
		return prod[31:0];
	endfunction

	// -vel scaled by restitution; -MIN stays MIN
	function automatic logic [31:0] reflect_vel(logic [31:0] vel);
		logic [31:0] flipped;
		flipped = -vel;
		return fixed_mul(longint'($signed(flipped)), longint'(box_bounce), RAND_FRAC);
	endfunction

	function automatic motion_t advance_particle(particle_t pin);
		motion_t     m;
		longint      dt_l;
		longint      acc_l;
		logic [31:0] half_dv;
		logic [31:0] spread;
		logic [31:0] respawn;
		int          k;
		dt_l = longint'(box_dt);
		for (k = 0; k < 3; k++) begin
			acc_l   = longint'($signed(pin.acc[k]));
			half_dv = fixed_mul(dt_l, acc_l, FRAC_BITS + 1);
			m.pos[k] = pin.pos[k] +
				fixed_mul(longint'($signed(pin.vel[k] + half_dv)), dt_l, FRAC_BITS);
			m.vel[k] = pin.vel[k] + fixed_mul(acc_l, dt_l, FRAC_BITS);
		end
		// respawn point: rand*right minus half the box width (magnitude, unsigned)
		spread = box_right - box_left;
		if (spread[31])
			spread = -spread;
		respawn = fixed_mul(longint'(pin.rnd), longint'($signed(box_right)), RAND_FRAC)
			- (spread >> 1);
		// x: low side first, then high side on the possibly respawned value
		if ($signed(m.pos[0]) < $signed(box_left)) begin
			m.pos[0] = respawn;
			m.vel[0] = reflect_vel(m.vel[0]);
		end
		if ($signed(box_right) < $signed(m.pos[0])) begin
			m.pos[0] = respawn;
			m.vel[0] = reflect_vel(m.vel[0]);
		end
		// y: mirror across the bound that was crossed, same order
		if ($signed(m.pos[1]) < $signed(box_low)) begin
			m.pos[1] = box_low + (box_low - m.pos[1]);
			m.vel[1] = reflect_vel(m.vel[1]);
		end
		if ($signed(box_up) < $signed(m.pos[1])) begin
			m.pos[1] = box_up - (m.pos[1] - box_up);
			m.vel[1] = reflect_vel(m.vel[1]);
		end
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic particle_t make_particle(input logic [31:0] px, py, pz,
		vx, vy, vz, ax, ay, az, input logic [15:0] rnd);
		particle_t p;
		p.pos = {pz, py, px};
		p.vel = {vz, vy, vx};
		p.acc = {az, ay, ax};
		p.rnd = rnd;
		return p;
	endfunction

	// Often near the anchor so bound crossings are frequent, plus small words near zero,
	// full-range words and the word extremes.
	function automatic logic [31:0] rand_word(logic [31:0] anchor);
		logic [31:0] nudge;
		nudge = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4, 5: return anchor + nudge;
			6, 7: return nudge;
			8: begin
				case ($urandom_range(0, 3))
					0: return MINW;
					1: return MAXW;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return anchor;
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		int        k;
		p.pos[0] = rand_word($urandom_range(0, 1) ? box_left : box_right);
		p.pos[1] = rand_word($urandom_range(0, 1) ? box_low : box_up);
		p.pos[2] = rand_word('0);
		for (k = 0; k < 3; k++) begin
			p.vel[k] = rand_word('0);
			p.acc[k] = rand_word('0);
		end
		p.rnd = 16'($urandom_range(0, 16'hFFFF));
		return p;
	endfunction

	// Queue all six box registers (optionally the undecoded slots after them)
	// and wait until the write channel has gone quiet.
	task automatic write_box(input logic [31:0] dt, left, right, up, low, bounce,
		input bit with_spare);
		reg_write_q.push_back('{IDX_TIME_STEP, dt});
		reg_write_q.push_back('{IDX_LEFT_BOUND, left});
		reg_write_q.push_back('{IDX_RIGHT_BOUND, right});
		reg_write_q.push_back('{IDX_UPPER_BOUND, up});
		reg_write_q.push_back('{IDX_LOWER_BOUND, low});
		reg_write_q.push_back('{IDX_BOUNCE_FACTOR, bounce});
		if (with_spare) begin
			reg_write_q.push_back('{IDX_SPARE_6, $urandom});
			reg_write_q.push_back('{IDX_SPARE_7, $urandom});
		end
		while (reg_write_q.size() != 0 || cfg_valid)
			@(posedge clk);
	endtask

	// Sender pause: let every offered request through and every result come
	// back, then leave the seven-stage pipe idle before going on.
	task automatic drain_pipeline();
		int waited;
		waited = 0;
		while ((particle_q.size() != 0 || s_tvalid || motion_due_q.size() != 0)
			&& waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (particle_q.size() != 0 || s_tvalid || motion_due_q.size() != 0) begin
			$error("pipeline did not drain: %0d requests unsent, %0d results missing",
				particle_q.size(), motion_due_q.size());
			fail_cnt++;
			motion_due_q.delete();
		end
		repeat (10) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Register write driver; keeps the bench copy of the box in step
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					IDX_TIME_STEP:     box_dt     = cfg_data[30:0];
					IDX_LEFT_BOUND:    box_left   = cfg_data;
					IDX_RIGHT_BOUND:   box_right  = cfg_data;
					IDX_UPPER_BOUND:   box_up     = cfg_data;
					IDX_LOWER_BOUND:   box_low    = cfg_data;
					IDX_BOUNCE_FACTOR: box_bounce = cfg_data[16:0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_write_q.size() != 0) begin
					cfg_valid <= 1'b1;
					cfg_index <= reg_write_q[0].idx;
					cfg_data  <= reg_write_q[0].data;
					void'(reg_write_q.pop_front());
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Particle driver: predict on accept, then offer the next request
	// (or idle) only when the current one is gone.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				motion_due_q.push_back(advance_particle(particle_t'(s_tdata)));
			if (!s_tvalid || s_tready) begin
				if (particle_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= particle_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor and receiver back-pressure. Twice in the run the
	// receiver holds m_tready low while requests are still queued, so the
	// pipe fills and s_tready must drop.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_monitor
		motion_t want;
		int      k;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (motion_due_q.size() == 0) begin
					$error("result request with no particle pending");
					fail_cnt++;
				end else begin
					want = motion_due_q.pop_front();
					for (k = 0; k < 6; k++) begin
						if (m_tdata[k*32 +: 32] !== want[k*32 +: 32]) begin
							$error("%s: expected %h, got %h", field_name[k],
								want[k*32 +: 32], m_tdata[k*32 +: 32]);
							fail_cnt++;
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (holds_done < 2 && results_seen >= 60 + 540*holds_done
				&& particle_q.size() >= 40) begin
				hold_left = 300;
				holds_done++;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int phase;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed, on the reset box (+-10, dt about 0.01, restitution one)
		particle_q.push_back(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000));
		particle_q.push_back(make_particle(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW,
			MAXW, MAXW, MAXW, 16'hFFFF));
		particle_q.push_back(make_particle(MINW, MINW, MINW, MINW, MINW, MINW,
			MINW, MINW, MINW, 16'h0000));
		particle_q.push_back(make_particle('1, '1, '1, '1, '1, '1, '1, '1, '1, 16'h8000));
		// plain flight inside the box
		particle_q.push_back(make_particle(ONE, 2*ONE, 3*ONE, HALF, -HALF, ONE,
			0, -10*ONE, 0, 16'h1234));
		// x under the left wall, then over the right wall
		particle_q.push_back(make_particle(-11*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 16'h4000));
		particle_q.push_back(make_particle(11*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 16'hC000));
		// y under the floor, then over the ceiling
		particle_q.push_back(make_particle(0, -10*ONE - HALF, 0, 0, -ONE, 0,
			0, 0, 0, 16'h0001));
		particle_q.push_back(make_particle(0, 10*ONE + HALF, 0, 0, ONE, 0,
			0, 0, 0, 16'h0002));
		// both walls hit with the most negative velocity: negation wraps
		particle_q.push_back(make_particle(-12*ONE, 12*ONE, 0, MINW, MINW, 0,
			0, 0, 0, 16'h7FFF));
		// z runs off the top of the word
		particle_q.push_back(make_particle(0, 0, 32'h7FFF_FFF0, 0, 0, MAXW,
			0, 0, MAXW, 16'h0000));
		// sitting exactly on the bounds is still inside
		particle_q.push_back(make_particle(-10*ONE, 10*ONE, 0, 0, 0, 0,
			0, 0, 0, 16'hFFFF));
		drain_pipeline();

		// Degenerate box for double exits: left = right = -10 so the respawn
		// lands above right again; floor = ceiling = 0 so a mirrored y goes
		// straight over the ceiling. Restitution above one.
		write_box(ONE, -10*ONE, -10*ONE, 0, 0, 32'h0001_FFFF, 1'b0);
		particle_q.push_back(make_particle(5*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 16'h0000));
		particle_q.push_back(make_particle(-20*ONE, 0, 0, -ONE, 0, 0,
			0, 0, 0, 16'h8000));
		particle_q.push_back(make_particle(0, -5*ONE, 0, 0, ONE, 0, 0, 0, 0, 16'h0000));
		particle_q.push_back(make_particle(0, 3*ONE, 0, 0, MINW, 0, 0, 0, 0, 16'hFFFF));
		drain_pipeline();

		// Random phases, one box setting each; phase 1 runs with no idling
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: write_box(655, -10*ONE, 10*ONE, 10*ONE, -10*ONE, 32'd65536, 1'b0);
				1: write_box(ONE, -100*ONE, 100*ONE, 100*ONE, -100*ONE, 32'd32768, 1'b0);
				// top bit of dt and high bits of the restitution must be dropped
				2: write_box('1, MINW, MAXW, MAXW, MINW, '1, 1'b0);
				// zero step, zero restitution, walls swapped
				3: write_box(0, MAXW, MINW, MINW, MAXW, 0, 1'b0);
				4: write_box(ONE >> 2, -5*ONE, -3*ONE, ONE, HALF, 32'd98304, 1'b1);
				default: write_box($urandom_range(0, 1) ? $urandom_range(0, 32'h0002_0000)
						: $urandom,
					rand_word(-10*ONE), rand_word(10*ONE), rand_word(10*ONE),
					rand_word(-10*ONE),
					$urandom_range(0, 3) != 0 ? $urandom_range(0, 131071) : $urandom,
					1'b1);
			endcase
			idle_pct = (phase == 1) ? 0 : 30;
			repeat (140) particle_q.push_back(rand_particle());
			drain_pipeline();
		end

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this
	initial begin
		#200000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
